@@ rtl/qbss_pkg.sv @@
// shared constants and types of the quote and bracket aware statement splitter
package qbss_pkg;

  // default stack depth for bracket nesting
  localparam int MAX_NESTING_DEFAULT = 16;

  // result kinds
  typedef logic [2:0] kind_t;
  localparam kind_t K_CHAR           = 3'd0;
  localparam kind_t K_END            = 3'd1;
  localparam kind_t K_DONE           = 3'd2;
  localparam kind_t K_SEMI_IN_BRACES = 3'd3;
  localparam kind_t K_MISMATCH       = 3'd4;
  localparam kind_t K_OVERFLOW       = 3'd5;
  localparam kind_t K_HALTED         = 3'd6;

  // characters of interest
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  // one result item as held in the output stages
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } result_t;

endpackage

@@ rtl/qbss_ram.sv @@
// generic single write port ram with registered read
module qbss_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/quote_bracket_statement_splitter.sv @@
// top level of the quote and bracket aware statement splitter
//
// Text enters one byte per item on the s_ channel; s_tlast marks the final
// item of a text, whose byte is dropped and which reports the outcome of the
// whole text and clears all state. Every input item gives exactly one result
// item on the m_ channel: a statement character with its byte, a statement
// end, text done, or an error kind. After an error every further byte reports
// halted until the final item.
// Throughput is one item per cycle while s_tready is high; each result is
// registered. The bracket stack lives in a small ram; the top entry is held
// in a register and the entry below it is read from the ram every cycle at
// the address the next depth implies, so a push or pop never waits for it.
// A two entry output stage (output register plus skid register) keeps
// s_tready high while one result waits; s_tready is low only while both hold
// results, and rises the cycle after m_tready takes the waiting item.
// Reset (rst, synchronous) empties the stack, clears the quote and halt
// flags and discards any results held in the output stage.
module quote_bracket_statement_splitter #(
  parameter int MAX_NESTING = qbss_pkg::MAX_NESTING_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tlast,   // final_item
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser    // [2:0] kind
);

  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int AW = $clog2(MAX_NESTING);

  // parser state
  logic          in_quote, in_quote_next;
  logic [7:0]    prev_byte, prev_byte_next;
  logic [DW-1:0] depth, depth_next;
  logic          halted, halted_next;
  logic          top_kind, top_kind_next;
  logic          below_kind;

  logic              accept;
  logic              push;
  qbss_pkg::result_t res;
  logic              top_curly;
  logic [DW-1:0]     depth_eff;
  logic [AW-1:0]     rd_addr;

  // output stage
  logic              out_valid, skid_valid;
  qbss_pkg::result_t out_res, skid_res;

  assign s_tready = !skid_valid;
  assign accept   = s_tvalid && s_tready;
  assign top_curly = (depth != '0) && top_kind;

  // per byte update of quote, stack and halt state
  always_comb begin
    in_quote_next  = in_quote;
    prev_byte_next = prev_byte;
    depth_next     = depth;
    halted_next    = halted;
    top_kind_next  = top_kind;
    push           = 1'b0;
    res.kind       = qbss_pkg::K_CHAR;
    res.data       = s_tdata;
    if (s_tlast) begin
      res.kind       = halted ? qbss_pkg::K_HALTED : qbss_pkg::K_DONE;
      in_quote_next  = 1'b0;
      prev_byte_next = '0;
      depth_next     = '0;
      halted_next    = 1'b0;
    end else if (halted) begin
      res.kind = qbss_pkg::K_HALTED;
    end else begin
      prev_byte_next = s_tdata;
      if (s_tdata == qbss_pkg::CH_SEMI && !in_quote && depth == '0) begin
        res.kind = qbss_pkg::K_END;
      end else if (s_tdata == qbss_pkg::CH_SEMI && !in_quote && top_curly) begin
        res.kind    = qbss_pkg::K_SEMI_IN_BRACES;
        halted_next = 1'b1;
      end else if (s_tdata == qbss_pkg::CH_QUOTE) begin
        if (!in_quote) begin
          in_quote_next = 1'b1;
        end else if (prev_byte != qbss_pkg::CH_BACKSLASH) begin
          in_quote_next = 1'b0;
        end
      end else if (!in_quote) begin
        if (s_tdata == qbss_pkg::CH_LCURLY || s_tdata == qbss_pkg::CH_LSQUARE) begin
          if (depth == DW'(MAX_NESTING)) begin
            res.kind    = qbss_pkg::K_OVERFLOW;
            halted_next = 1'b1;
          end else begin
            push          = 1'b1;
            top_kind_next = (s_tdata == qbss_pkg::CH_LCURLY);
            depth_next    = depth + DW'(1);
          end
        end else if (s_tdata == qbss_pkg::CH_RCURLY
                     || s_tdata == qbss_pkg::CH_RSQUARE) begin
          if (depth == '0 || top_curly != (s_tdata == qbss_pkg::CH_RCURLY)) begin
            res.kind    = qbss_pkg::K_MISMATCH;
            halted_next = 1'b1;
          end else begin
            depth_next    = depth - DW'(1);
            top_kind_next = below_kind;
          end
        end
      end
    end
    if (res.kind != qbss_pkg::K_CHAR) begin
      res.data = '0;
    end
  end

  // entry below the top, fetched for the depth of the next cycle
  assign depth_eff = accept ? depth_next : depth;
  assign rd_addr   = (depth_eff > DW'(1)) ? AW'(depth_eff - DW'(2)) : '0;

  qbss_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NESTING)
  ) u_stack (
    .clk     (clk),
    .wr_en   (accept && push),
    .wr_addr (AW'(depth)),
    .wr_data (top_kind_next),
    .rd_addr (rd_addr),
    .rd_data (below_kind)
  );

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_quote  <= 1'b0;
      prev_byte <= '0;
      depth     <= '0;
      halted    <= 1'b0;
      top_kind  <= 1'b0;
    end else if (accept) begin
      in_quote  <= in_quote_next;
      prev_byte <= prev_byte_next;
      depth     <= depth_next;
      halted    <= halted_next;
      top_kind  <= top_kind_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= res;
      end
    end else if (accept) begin
      skid_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res.data;
  assign m_tuser  = out_res.kind;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output register is empty");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_NESTING))
    else $error("nesting depth beyond stack size");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (depth == '0 && !halted && !in_quote))
    else $error("final item did not clear parser state");

  a_halt_holds: assert property (@(posedge clk) disable iff (rst)
    (accept && halted && !s_tlast) |=> (halted && $stable(depth)))
    else $error("halted state changed on a non-final item");

endmodule

@@ dv/tb_quote_bracket_statement_splitter.sv @@
// testbench of the quote and bracket aware statement splitter
module tb_quote_bracket_statement_splitter;

  localparam int MAX_NESTING = qbss_pkg::MAX_NESTING_DEFAULT;
  localparam int N_PHASES = 4;
  localparam int PHASE_ITEMS = 200;

  // one stimulus row: text byte, final flag and an optional typed-in result
  typedef struct packed {
    logic [7:0]      text;
    logic            fin;
    logic            typed;
    qbss_pkg::kind_t kind;
    logic [7:0]      data;
  } text_row_t;

  // directed rows, typed results only where they are obvious
  localparam text_row_t DIRECTED_ROWS [26] = '{
    '{8'h61, 1'b0, 1'b1, qbss_pkg::K_CHAR, 8'h61},                  // plain character
    '{8'h00, 1'b0, 1'b1, qbss_pkg::K_CHAR, 8'h00},                  // lowest byte
    '{8'hFF, 1'b0, 1'b1, qbss_pkg::K_CHAR, 8'hFF},                  // highest byte
    '{qbss_pkg::CH_SEMI, 1'b0, 1'b1, qbss_pkg::K_END, 8'h00},       // statement end
    '{qbss_pkg::CH_LSQUARE, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},
    '{qbss_pkg::CH_SEMI, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},      // semicolon in squares
    '{qbss_pkg::CH_LCURLY, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},
    '{qbss_pkg::CH_QUOTE, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},     // quote opens
    '{qbss_pkg::CH_SEMI, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},      // semicolon quoted
    '{qbss_pkg::CH_BACKSLASH, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},
    '{qbss_pkg::CH_QUOTE, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},     // escaped quote
    '{qbss_pkg::CH_RCURLY, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},    // closer quoted
    '{qbss_pkg::CH_QUOTE, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},     // quote closes
    '{qbss_pkg::CH_RCURLY, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},
    '{qbss_pkg::CH_RSQUARE, 1'b0, 1'b0, qbss_pkg::K_CHAR, 8'h00},
    '{qbss_pkg::CH_RSQUARE, 1'b0, 1'b1, qbss_pkg::K_MISMATCH, 8'h00}, // closer on empty stack
    '{8'h78, 1'b0, 1'b1, qbss_pkg::K_HALTED, 8'h00},                // byte while halted
    '{8'h7A, 1'b1, 1'b1, qbss_pkg::K_HALTED, 8'h00},                // final while halted
    '{qbss_pkg::CH_LCURLY, 1'b0, 1'b1, qbss_pkg::K_CHAR, qbss_pkg::CH_LCURLY},
    '{qbss_pkg::CH_SEMI, 1'b0, 1'b1, qbss_pkg::K_SEMI_IN_BRACES, 8'h00}, // semicolon in braces
    '{8'hFF, 1'b1, 1'b1, qbss_pkg::K_HALTED, 8'h00},
    '{qbss_pkg::CH_LSQUARE, 1'b0, 1'b1, qbss_pkg::K_CHAR, qbss_pkg::CH_LSQUARE},
    '{qbss_pkg::CH_RCURLY, 1'b0, 1'b1, qbss_pkg::K_MISMATCH, 8'h00}, // closer of wrong kind
    '{8'h00, 1'b1, 1'b1, qbss_pkg::K_HALTED, 8'h00},
    '{qbss_pkg::CH_QUOTE, 1'b0, 1'b1, qbss_pkg::K_CHAR, qbss_pkg::CH_QUOTE}, // quote left open
    '{8'h00, 1'b1, 1'b1, qbss_pkg::K_DONE, 8'h00}                   // final, open quote is fine
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;

  quote_bracket_statement_splitter #(.MAX_NESTING(MAX_NESTING)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  text_row_t         pending_text [$];
  qbss_pkg::result_t awaited_results [$];
  text_row_t         driven_row;
  qbss_pkg::result_t split_out;
  qbss_pkg::result_t typed_out;
  qbss_pkg::result_t seen_want;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                phase_items = 0;
  int                result_count = 0;
  int                errors = 0;

  // splitter state as the predictor sees it
  logic       sp_in_quote = 1'b0;
  logic [7:0] sp_prev = 8'h00;
  logic       sp_curly [MAX_NESTING];
  int         sp_depth = 0;
  logic       sp_halted = 1'b0;

  task automatic report_mismatch(input string msg);
    if (errors < 40) $display("mismatch at result %0d: %s", result_count, msg);
    errors++;
  endtask

  // next result of the splitter for one accepted item, state updated
  function automatic qbss_pkg::result_t split_byte(input logic [7:0] b, input logic fin);
    qbss_pkg::result_t r;
    r.kind = qbss_pkg::K_CHAR;
    r.data = b;
    if (fin) begin
      r.kind = sp_halted ? qbss_pkg::K_HALTED : qbss_pkg::K_DONE;
      r.data = 8'h00;
      sp_in_quote = 1'b0;
      sp_prev = 8'h00;
      sp_depth = 0;
      sp_halted = 1'b0;
      return r;
    end
    if (sp_halted) begin
      r.kind = qbss_pkg::K_HALTED;
      r.data = 8'h00;
      return r;
    end
    if (b == qbss_pkg::CH_SEMI && !sp_in_quote && sp_depth == 0) begin
      r.kind = qbss_pkg::K_END;
    end else if (b == qbss_pkg::CH_SEMI && !sp_in_quote && sp_curly[sp_depth-1]) begin
      r.kind = qbss_pkg::K_SEMI_IN_BRACES;
      sp_halted = 1'b1;
    end else if (b == qbss_pkg::CH_QUOTE) begin
      if (!sp_in_quote) sp_in_quote = 1'b1;
      else if (sp_prev != qbss_pkg::CH_BACKSLASH) sp_in_quote = 1'b0;
    end else if (!sp_in_quote) begin
      if (b == qbss_pkg::CH_LCURLY || b == qbss_pkg::CH_LSQUARE) begin
        if (sp_depth >= MAX_NESTING) begin
          r.kind = qbss_pkg::K_OVERFLOW;
          sp_halted = 1'b1;
        end else begin
          sp_curly[sp_depth] = (b == qbss_pkg::CH_LCURLY);
          sp_depth++;
        end
      end else if (b == qbss_pkg::CH_RCURLY || b == qbss_pkg::CH_RSQUARE) begin
        if (sp_depth == 0 || sp_curly[sp_depth-1] != (b == qbss_pkg::CH_RCURLY)) begin
          r.kind = qbss_pkg::K_MISMATCH;
          sp_halted = 1'b1;
        end else begin
          sp_depth--;
        end
      end
    end
    if (r.kind != qbss_pkg::K_CHAR) r.data = 8'h00;
    sp_prev = b;
    return r;
  endfunction

  task automatic add_text(input logic [7:0] b, input logic fin);
    text_row_t row;
    row.text = b;
    row.fin = fin;
    row.typed = 1'b0;
    row.kind = qbss_pkg::K_CHAR;
    row.data = 8'h00;
    pending_text.insert(pending_text.size(), row);
    phase_items++;
  endtask

  // one whole text: statements with random content, sometimes a broken tail
  task automatic gen_text();
    bit         open_kinds [$];
    int         n_stmt;
    int         n_chr;
    int         r;
    int         m;
    bit         broken;
    bit         last_curly;
    logic [7:0] c;
    n_stmt = $urandom_range(0, 4);
    for (int s = 0; s < n_stmt; s++) begin
      n_chr = $urandom_range(1, 12);
      for (int i = 0; i < n_chr; i++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          add_text(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 24 && open_kinds.size() < MAX_NESTING) begin
          open_kinds.insert(open_kinds.size(), 1'($urandom_range(0, 1)));
          add_text(open_kinds[$] ? qbss_pkg::CH_LCURLY : qbss_pkg::CH_LSQUARE, 1'b0);
        end else if (r < 36 && open_kinds.size() > 0) begin
          last_curly = open_kinds[$];
          open_kinds.delete(open_kinds.size() - 1);
          add_text(last_curly ? qbss_pkg::CH_RCURLY : qbss_pkg::CH_RSQUARE, 1'b0);
        end else if (r < 46) begin
          // quoted span with specials and escapes inside
          add_text(qbss_pkg::CH_QUOTE, 1'b0);
          m = $urandom_range(0, 6);
          c = qbss_pkg::CH_QUOTE;
          for (int j = 0; j < m; j++) begin
            case ($urandom_range(0, 5))
              0: c = qbss_pkg::CH_SEMI;
              1: c = qbss_pkg::CH_LCURLY;
              2: c = qbss_pkg::CH_RSQUARE;
              3: begin
                add_text(qbss_pkg::CH_BACKSLASH, 1'b0);
                c = qbss_pkg::CH_QUOTE;
              end
              4: c = qbss_pkg::CH_BACKSLASH;
              default: c = 8'($urandom_range(8'h61, 8'h7A));
            endcase
            add_text(c, 1'b0);
          end
          if (c == qbss_pkg::CH_BACKSLASH) add_text(8'h65, 1'b0);
          add_text(qbss_pkg::CH_QUOTE, 1'b0);
        end else if (r < 54 && open_kinds.size() > 0 && !open_kinds[$]) begin
          add_text(qbss_pkg::CH_SEMI, 1'b0);
        end else begin
          add_text(8'($urandom_range(8'h41, 8'h7A)), 1'b0);
        end
      end
      while (open_kinds.size() > 0) begin
        last_curly = open_kinds[$];
        open_kinds.delete(open_kinds.size() - 1);
        add_text(last_curly ? qbss_pkg::CH_RCURLY : qbss_pkg::CH_RSQUARE, 1'b0);
      end
      add_text(qbss_pkg::CH_SEMI, 1'b0);
    end

    // tail of the text
    broken = 1'b1;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      add_text($urandom_range(0, 1) ? qbss_pkg::CH_RCURLY : qbss_pkg::CH_RSQUARE, 1'b0);
    end else if (r < 16) begin
      if ($urandom_range(0, 1)) begin
        add_text(qbss_pkg::CH_LCURLY, 1'b0);
        add_text(qbss_pkg::CH_RSQUARE, 1'b0);
      end else begin
        add_text(qbss_pkg::CH_LSQUARE, 1'b0);
        add_text(qbss_pkg::CH_RCURLY, 1'b0);
      end
    end else if (r < 22) begin
      add_text(qbss_pkg::CH_LCURLY, 1'b0);
      add_text(qbss_pkg::CH_SEMI, 1'b0);
    end else if (r < 28) begin
      for (int k = 0; k <= MAX_NESTING; k++)
        add_text($urandom_range(0, 1) ? qbss_pkg::CH_LCURLY : qbss_pkg::CH_LSQUARE, 1'b0);
    end else begin
      broken = 1'b0;
      if (r < 36) begin
        // nesting to the full depth and back
        for (int k = 0; k < MAX_NESTING; k++) begin
          open_kinds.insert(open_kinds.size(), 1'($urandom_range(0, 1)));
          add_text(open_kinds[$] ? qbss_pkg::CH_LCURLY : qbss_pkg::CH_LSQUARE, 1'b0);
        end
        while (open_kinds.size() > 0) begin
          last_curly = open_kinds[$];
          open_kinds.delete(open_kinds.size() - 1);
          add_text(last_curly ? qbss_pkg::CH_RCURLY : qbss_pkg::CH_RSQUARE, 1'b0);
        end
      end else if (r < 60) begin
        repeat ($urandom_range(1, 5)) add_text(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
      end
    end
    if (broken) repeat ($urandom_range(0, 3)) add_text(8'($urandom_range(0, 255)), 1'b0);
    add_text(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // sender: hold the item until accepted, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        split_out = split_byte(driven_row.text, driven_row.fin);
        typed_out.kind = driven_row.kind;
        typed_out.data = driven_row.data;
        awaited_results.insert(awaited_results.size(),
                               driven_row.typed ? typed_out : split_out);
      end
      if (!s_tvalid || s_tready) begin
        if (pending_text.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driven_row = pending_text.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= driven_row.text;
          s_tlast <= driven_row.fin;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item kind %0d byte %02h", m_tuser, m_tdata));
      end else begin
        seen_want = awaited_results.pop_front();
        if (m_tuser !== seen_want.kind)
          report_mismatch($sformatf("kind %0d, want %0d", m_tuser, seen_want.kind));
        if (m_tdata !== seen_want.data)
          report_mismatch($sformatf("byte %02h, want %02h", m_tdata, seen_want.data));
      end
      result_count++;
    end
  end

  // phases of sender idling and receiver stalls, directed rows first
  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < N_PHASES; p++) begin
      @(negedge clk);
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      if (p == 0)
        foreach (DIRECTED_ROWS[i]) pending_text.insert(pending_text.size(), DIRECTED_ROWS[i]);
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) gen_text();
      while (pending_text.size() > 0 || s_tvalid || awaited_results.size() > 0)
        @(negedge clk);
    end
    repeat (10) @(negedge clk);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // run limit
  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
